@@ rtl/itoa_pkg.sv @@
// Package with the payload types, character constants and helpers of the integer to text block.
`timescale 1ns / 1ps
package itoa_pkg;

  localparam int ValueWidth = 32;
  localparam int RadixWidth = 6;
  localparam int CharWidth  = 7;
  localparam int MaxChars   = ValueWidth + 1;

  localparam logic [RadixWidth-1:0] RadixMin = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax = 6'd36;

  localparam logic [CharWidth-1:0] DigitZero = 7'h30;
  localparam logic [CharWidth-1:0] DigitNine = 7'h39;
  localparam logic [CharWidth-1:0] LetterGap = 7'h07;
  localparam logic [CharWidth-1:0] MinusSign = 7'h2D;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [RadixWidth-1:0]        radix;
  } in_req_t;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 is_last;
  } out_rsp_t;

  // Radix values outside two to thirty-six are pulled to the nearest end.
  function automatic logic [RadixWidth-1:0] clamp_radix(input logic [RadixWidth-1:0] r);
    logic [RadixWidth-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

  // Digit values of ten and above map onto the upper-case letters.
  function automatic logic [CharWidth-1:0] digit_char(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] c;
    c = DigitZero + {1'b0, d};
    if (c > DigitNine) c = c + LetterGap;
    return c;
  endfunction

endpackage

@@ rtl/signed_int_to_ascii_radix.sv @@
// Top level of the signed integer to ASCII text converter.
`timescale 1ns / 1ps
// Converts one signed 32-bit integer per request into its text in radix 2 to 36, most
// significant character first, one character per output request, with is_last on the final
// one; negative values get a leading minus sign. One restoring divider, shifting one quotient
// bit a cycle, is shared by all digits, which are worked out one after another. Digits are
// pushed onto a 33-entry stack memory as they are found, least significant first, with the
// minus sign of a negative value pushed last, and are popped in reverse; each pop reads the
// stack in StRead before the character is shown in StShow. No new request is taken until
// the last character has been delivered.
module signed_int_to_ascii_radix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  itoa_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output itoa_pkg::out_rsp_t out_rsp_o
);
  import itoa_pkg::*;

  localparam int CntW = $clog2(MaxChars + 1);
  localparam int IdxW = $clog2(MaxChars);
  localparam int BitW = $clog2(ValueWidth);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StSign,
    StRead,
    StShow
  } state_e;

  state_e                 state_q;
  logic [ValueWidth-1:0]  mag_q;
  logic [RadixWidth-1:0]  rem_q;
  logic [RadixWidth-1:0]  radix_q;
  logic                   neg_q;
  logic [BitW-1:0]        bit_q;
  logic [CntW-1:0]        cnt_q;
  logic [CharWidth-1:0]   rd_q;
  logic [CharWidth-1:0]   stack_mem [MaxChars];

  logic [ValueWidth-1:0]  in_value;
  logic                   in_neg;
  logic [ValueWidth-1:0]  in_mag;
  logic [RadixWidth:0]    trial;
  logic [RadixWidth:0]    diff;
  logic                   ge;
  logic [RadixWidth-1:0]  rem_nx;
  logic [ValueWidth-1:0]  quo_nx;
  logic                   last_bit;
  logic                   wr_en;
  logic [CharWidth-1:0]   wr_data;
  logic [CntW-1:0]        cnt_dec;

  // Two's complement magnitude taken as unsigned, so the most negative value stays exact.
  assign in_value = in_req_i.value;
  assign in_neg   = in_value[ValueWidth-1];
  assign in_mag   = in_neg ? (~in_value + {{(ValueWidth-1){1'b0}}, 1'b1}) : in_value;

  // One restoring division step: bring down the next dividend bit and try the subtraction.
  assign trial    = {rem_q, mag_q[ValueWidth-1]};
  assign diff     = trial - {1'b0, radix_q};
  assign ge       = trial >= {1'b0, radix_q};
  assign rem_nx   = ge ? diff[RadixWidth-1:0] : trial[RadixWidth-1:0];
  assign quo_nx   = {mag_q[ValueWidth-2:0], ge};
  assign last_bit = bit_q == BitW'(ValueWidth - 1);

  assign wr_en    = ((state_q == StDiv) && last_bit) || (state_q == StSign);
  assign wr_data  = (state_q == StSign) ? MinusSign : digit_char(rem_nx);
  assign cnt_dec  = cnt_q - CntW'(1);

  assign in_stall_o           = state_q != StIdle;
  assign out_valid_o          = state_q == StShow;
  assign out_rsp_o.character  = rd_q;
  assign out_rsp_o.is_last    = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[cnt_q[IdxW-1:0]] <= wr_data;
    end
    if (state_q == StRead) begin
      rd_q <= stack_mem[cnt_dec[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mag_q   <= '0;
      rem_q   <= '0;
      radix_q <= RadixMin;
      neg_q   <= 1'b0;
      bit_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            mag_q   <= in_mag;
            radix_q <= clamp_radix(in_req_i.radix);
            neg_q   <= in_neg;
            rem_q   <= '0;
            bit_q   <= '0;
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          mag_q <= quo_nx;
          if (last_bit) begin
            // The remainder has just been pushed; the quotient is the next dividend.
            cnt_q <= cnt_q + CntW'(1);
            bit_q <= '0;
            rem_q <= '0;
            if (quo_nx == '0) begin
              state_q <= neg_q ? StSign : StRead;
            end
          end else begin
            rem_q <= rem_nx;
            bit_q <= bit_q + BitW'(1);
          end
        end
        StSign: begin
          cnt_q   <= cnt_q + CntW'(1);
          state_q <= StRead;
        end
        StRead: begin
          cnt_q   <= cnt_dec;
          state_q <= StShow;
        end
        StShow: begin
          if (!out_stall_i) begin
            state_q <= (cnt_q == '0) ? StIdle : StRead;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_no_accept_while_showing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request could be taken while a character is on show");

  a_stack_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxChars))
    else $error("character stack overran its depth");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_rsp_o.is_last) |=> !in_stall_o)
    else $error("block not ready after the last character was taken");

  a_positive_pop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && last_bit && quo_nx == '0 && !neg_q) |=> ##1 out_valid_o)
    else $error("first character did not appear after the final division");

endmodule

@@ dv/signed_int_to_ascii_radix_test.sv @@
// Self-checking testbench of the signed integer to ASCII text converter.
`timescale 1ns / 1ps

class text_checker;
  localparam logic [6:0] LetterA = 7'h41;

  itoa_pkg::out_rsp_t chars_due[$];
  int unsigned requests_seen;
  int unsigned negatives_seen;
  int unsigned chars_checked;
  int unsigned mismatches;

  function new();
    requests_seen  = 0;
    negatives_seen = 0;
    chars_checked  = 0;
    mismatches     = 0;
  endfunction

  // Spells out the value in its radix and queues every character that the block owes.
  function void note_request(itoa_pkg::in_req_t req);
    int unsigned        base;
    logic [31:0]        mag;
    logic [31:0]        digit;
    logic               negative;
    logic [6:0]         text[$];
    itoa_pkg::out_rsp_t rsp;
    base = req.radix;
    if (base < 2) base = 2;
    if (base > 36) base = 36;
    negative = req.value[31];
    // Taken as unsigned, so the most negative value keeps its full magnitude.
    mag = negative ? (~req.value + 32'd1) : req.value;
    do begin
      digit = mag % base;
      text.push_front(digit < 10 ? itoa_pkg::DigitZero + 7'(digit)
                                 : LetterA + 7'(digit - 10));
      mag = mag / base;
    end while (mag != 0);
    if (negative) text.push_front(itoa_pkg::MinusSign);
    foreach (text[i]) begin
      rsp.character = text[i];
      rsp.is_last   = (i == text.size() - 1);
      chars_due.push_back(rsp);
    end
    requests_seen++;
    if (negative) negatives_seen++;
  endfunction

  function void check_char(itoa_pkg::out_rsp_t got);
    itoa_pkg::out_rsp_t want;
    chars_checked++;
    if (chars_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected character %h (is_last %b) with nothing outstanding",
                 got.character, got.is_last);
      return;
    end
    want = chars_due.pop_front();
    if (got.character !== want.character || got.is_last !== want.is_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on character %0d: expected %h/%b, got %h/%b", chars_checked,
                 want.character, want.is_last, got.character, got.is_last);
    end
  endfunction

  function int unsigned pending();
    return chars_due.size();
  endfunction
endclass

module signed_int_to_ascii_radix_test;
  localparam int unsigned CycleLimit   = 1_500_000;
  localparam int unsigned RandomCount  = 200;
  localparam int unsigned DirectedSize = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  itoa_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  itoa_pkg::out_rsp_t out_rsp_o;

  text_checker  board;
  int unsigned  cycles;
  bit           in_idle_on;
  bit           out_idle_on;
  bit [63:0]    radix_hit;

  signed_int_to_ascii_radix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d characters outstanding", cycles,
               board.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_request(itoa_pkg::in_req_t req);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 12) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(req);
    radix_hit[req.radix] = 1'b1;
  endtask

  function automatic itoa_pkg::in_req_t random_request();
    itoa_pkg::in_req_t req;
    logic [31:0]       mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: req.value = $urandom;
      4, 5: begin
        mag = $urandom_range(0, 2000);
        req.value = $urandom_range(0, 1) ? -mag : mag;
      end
      6: begin
        case ($urandom_range(0, 4))
          0: req.value = 32'sh8000_0000;
          1: req.value = 32'sh7FFF_FFFF;
          2: req.value = 0;
          3: req.value = -1;
          default: req.value = 1;
        endcase
      end
      default: begin
        // Shifting spreads the magnitudes evenly over the bit lengths.
        mag = $urandom >> $urandom_range(0, 31);
        req.value = $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
    req.radix = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(2, 36))
                                             : 6'($urandom_range(0, 63));
    return req;
  endfunction

  // Receiver side: holds the stall for a drawn number of cycles before each character.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = out_idle_on ? $urandom_range(0, 12) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      board.check_char(out_rsp_o);
    end
  end

  initial begin
    logic signed [31:0] dir_value[DirectedSize];
    logic [5:0]         dir_radix[DirectedSize];
    itoa_pkg::in_req_t  req;
    dir_value = '{0, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  35, 10, 9, 36, 255, -255, 5, 5, -100, 100, 32'sh8000_0000, -35, 123456789};
    dir_radix = '{6'd10, 6'd2, 6'd10, 6'd2, 6'd2, 6'd36, 6'd36,
                  6'd36, 6'd16, 6'd10, 6'd36, 6'd16, 6'd16, 6'd0, 6'd1, 6'd37, 6'd63,
                  6'd10, 6'd36, 6'd8};

    board       = new();
    cycles      = 0;
    radix_hit   = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes, letter digits and radix values outside the legal range.
    for (int i = 0; i < DirectedSize; i++) begin
      req.value = dir_value[i];
      req.radix = dir_radix[i];
      send_request(req);
    end

    for (int i = 0; i < RandomCount; i++) begin
      // Idling changes character every twenty requests, with calm stretches in between.
      if (i % 20 == 0) begin
        in_idle_on  = $urandom_range(0, 2) != 0;
        out_idle_on = $urandom_range(0, 2) != 0;
      end
      send_request(random_request());
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    // Long enough for a stray extra character to show.
    repeat (200) @(posedge clk_i);

    $display("Converted %0d requests (%0d negative) into %0d characters, %0d mismatches.",
             board.requests_seen, board.negatives_seen, board.chars_checked,
             board.mismatches);
    $display("Radix codes exercised: %0d of 64, run took %0d cycles.",
             $countones(radix_hit), cycles);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/itoa_pkg.sv
rtl/signed_int_to_ascii_radix.sv
dv/signed_int_to_ascii_radix_test.sv
